// ----- rtl/core/ffsa_pkg.sv -----
// Shared types and codes for the first-fit segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_RESIZE  = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_IGN  = 2'd2;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  localparam logic [31:0] HEAP_LIMIT_RST = 32'h9000_0000;
  localparam logic [31:0] SIZE_MAX       = 32'hFFFF_FFF8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] req_size;
    logic [31:0] payload_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_addr;
    logic [31:0] copy_source;
    logic [31:0] copy_bytes;
  } out_item_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
    logic        free;
  } seg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MATCH_FIT,
    OP_MATCH_ADDR,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wlen;
    seg_t     ent;
  } cell_cmd_t;

endpackage

// ----- rtl/core/ffsa_cell.sv -----
// One segment table cell: holds an entry, matches it, shifts with its neighbors.
`timescale 1ns / 1ps
module ffsa_cell
  import ffsa_pkg::*;
#(
  parameter int SEGMENTS     = 64,
  parameter int HEADER_BYTES = 16,
  parameter int INDEX        = 0,
  parameter int IW           = $clog2(SEGMENTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] pos,
  input  logic [IW:0]   count,
  input  seg_t          left_ent,
  input  seg_t          right_ent,
  output seg_t          ent,
  output logic          flag
);

  seg_t ent_r;
  logic flag_r;
  logic live;
  logic at_pos;
  logic above_pos;

  assign live      = (IW+1)'(INDEX) < count;
  assign at_pos    = IW'(INDEX) == pos;
  assign above_pos = IW'(INDEX) > pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_MATCH_FIT:  flag_r <= live && ent_r.free && (ent_r.len >= cmd.ent.len);
        OP_MATCH_ADDR: flag_r <= live &&
                         (({1'b0, ent_r.base} + 33'(HEADER_BYTES)) == {1'b0, cmd.ent.base});
        default:       flag_r <= flag_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WRITE: begin
        if (at_pos) begin
          ent_r.free <= cmd.ent.free;
          if (cmd.wlen) ent_r.len <= cmd.ent.len;
        end
      end
      OP_INSERT: begin
        if (at_pos) ent_r <= cmd.ent;
        else if (above_pos) ent_r <= left_ent;
      end
      OP_REMOVE: begin
        if (at_pos || above_pos) ent_r <= right_ent;
      end
      default: ent_r <= ent_r;
    endcase
  end

  assign ent  = ent_r;
  assign flag = flag_r;

endmodule

// ----- rtl/core/ffsa_pick.sv -----
// First-hit selection over the cell flags and readout of the hit and its neighbors.
`timescale 1ns / 1ps
module ffsa_pick
  import ffsa_pkg::*;
#(
  parameter int SEGMENTS = 64,
  parameter int IW       = $clog2(SEGMENTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [SEGMENTS-1:0] flags,
  input  seg_t          ents [SEGMENTS],
  output logic          found,
  output logic [IW-1:0] idx,
  output seg_t          cur,
  output seg_t          nxt,
  output seg_t          prv
);

  logic [SEGMENTS-1:0] sel_r;
  logic                found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      found_r <= 1'b0;
    end else begin
      sel_r   <= flags & (~flags + SEGMENTS'(1));
      found_r <= |flags;
    end
  end

  always_comb begin
    cur = '0;
    nxt = '0;
    prv = '0;
    idx = '0;
    for (int k = 0; k < SEGMENTS; k++) begin
      if (sel_r[k]) begin
        cur = cur | ents[k];
        idx = idx | IW'(k);
      end
    end
    for (int k = 0; k < SEGMENTS - 1; k++) begin
      if (sel_r[k]) nxt = nxt | ents[k+1];
    end
    for (int k = 1; k < SEGMENTS; k++) begin
      if (sel_r[k]) prv = prv | ents[k-1];
    end
  end

  assign found = found_r;

endmodule

// ----- rtl/core/first_fit_segment_allocator.sv -----
// Top level: command sequencer driving a row of segment table cells.
// One item at a time in the sequencer, plus the output stage.
// Each table search runs match in the cells, then pick, then readout;
// each insert, remove or write of the table is one command to the cell row.
// Reset is synchronous: count, break and control clear; entries stay unwritten.
`timescale 1ns / 1ps
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int SEGMENTS     = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(SEGMENTS);
  localparam int CW = IW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_MATCH, S_PICK, S_READ, S_ADEC, S_ASPLIT_W, S_ASPLIT_I,
    S_AUSE, S_AEXT, S_FDEC, S_RABS, S_RABS_R, S_R1, S_R1RM, S_R2, S_R2RM, S_R3,
    S_R3RM, S_RDONE, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    RET_ALLOC, RET_REL, RET_RZ0, RET_RSZ, RET_MOVE, RET_MOVEREL
  } ret_t;

  state_t state_r;
  ret_t   ret_r;
  logic   flow_alloc_r;
  logic [1:0]  cmd_r;
  logic [31:0] size_r, need_r, addr_r;
  logic [31:0] heap_base_r, heap_limit_r, brk_r;
  logic        known_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] idx_r;
  seg_t cur_r, nxt_r, prv_r;
  logic nxt_ok_r, prv_ok_r, found_r;
  logic [31:0] new_addr_r, old_len_r;
  logic [1:0]  st_r;
  logic [31:0] res_r, src_r, byt_r;
  out_item_t   out_r;
  logic        out_valid_r;

  cell_cmd_t     ccmd;
  logic [IW-1:0] cpos;
  seg_t          ents [SEGMENTS];
  logic [SEGMENTS-1:0] flags;
  logic          p_found;
  logic [IW-1:0] p_idx;
  seg_t          p_cur, p_nxt, p_prv;

  logic [31:0] sum_nxt, sum_prv;
  logic        merge_nxt, merge_prv, fits_split, ext_over;
  logic [CW-1:0] idx_p1;

  assign sum_nxt   = cur_r.len + 32'(HEADER_BYTES) + nxt_r.len;
  assign sum_prv   = prv_r.len + 32'(HEADER_BYTES) + cur_r.len;
  assign merge_nxt = nxt_ok_r && nxt_r.free;
  assign merge_prv = prv_ok_r && prv_r.free;
  assign idx_p1    = {1'b0, idx_r} + CW'(1);
  assign fits_split = ({2'b0, cur_r.len} >= ({2'b0, need_r} + 34'(HEADER_BYTES) + 34'd8)) &&
                      (count_r < CW'(SEGMENTS));
  assign ext_over  = ({2'b0, brk_r} + 34'(HEADER_BYTES) + {2'b0, need_r}) >
                     {2'b0, heap_limit_r};

  always_comb begin
    ccmd = '0;
    cpos = idx_r;
    case (state_r)
      S_MATCH: begin
        ccmd.op       = flow_alloc_r ? OP_MATCH_FIT : OP_MATCH_ADDR;
        ccmd.ent.len  = need_r;
        ccmd.ent.base = addr_r;
      end
      S_ASPLIT_W: begin
        ccmd.op      = OP_WRITE;
        ccmd.wlen    = 1'b1;
        ccmd.ent.len = need_r;
      end
      S_ASPLIT_I: begin
        ccmd.op       = OP_INSERT;
        cpos          = idx_p1[IW-1:0];
        ccmd.ent.base = cur_r.base + 32'(HEADER_BYTES) + need_r;
        ccmd.ent.len  = cur_r.len - need_r - 32'(HEADER_BYTES);
        ccmd.ent.free = 1'b1;
      end
      S_AUSE: ccmd.op = OP_WRITE;
      S_AEXT: begin
        ccmd.op       = OP_INSERT;
        cpos          = count_r[IW-1:0];
        ccmd.ent.base = brk_r;
        ccmd.ent.len  = need_r;
      end
      S_RABS: begin
        ccmd.op      = OP_WRITE;
        ccmd.wlen    = 1'b1;
        ccmd.ent.len = sum_nxt;
      end
      S_RABS_R, S_R1RM, S_R2RM: begin
        ccmd.op = OP_REMOVE;
        cpos    = idx_p1[IW-1:0];
      end
      S_R1: begin
        ccmd.op       = OP_WRITE;
        ccmd.wlen     = merge_nxt;
        ccmd.ent.len  = sum_nxt;
        ccmd.ent.free = 1'b1;
      end
      S_R2: begin
        ccmd.op       = merge_prv ? OP_WRITE : OP_NONE;
        cpos          = idx_r - IW'(1);
        ccmd.wlen     = 1'b1;
        ccmd.ent.len  = sum_prv;
        ccmd.ent.free = 1'b1;
      end
      S_R3RM: ccmd.op = OP_REMOVE;
      default: ccmd = '0;
    endcase
  end

  for (genvar k = 0; k < SEGMENTS; k++) begin : g_cell
    seg_t lft, rgt;
    if (k == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid
      assign lft = ents[k-1];
    end
    if (k == SEGMENTS - 1) begin : g_last
      assign rgt = ents[k];
    end else begin : g_inner
      assign rgt = ents[k+1];
    end
    ffsa_cell #(
      .SEGMENTS(SEGMENTS), .HEADER_BYTES(HEADER_BYTES), .INDEX(k), .IW(IW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(ccmd), .pos(cpos), .count(count_r),
      .left_ent(lft), .right_ent(rgt), .ent(ents[k]), .flag(flags[k])
    );
  end

  ffsa_pick #(.SEGMENTS(SEGMENTS), .IW(IW)) u_pick (
    .clk(clk), .rst_n(rst_n), .flags(flags), .ents(ents),
    .found(p_found), .idx(p_idx), .cur(p_cur), .nxt(p_nxt), .prv(p_prv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= RET_ALLOC;
      flow_alloc_r <= 1'b0;
      heap_base_r  <= '0;
      heap_limit_r <= HEAP_LIMIT_RST;
      brk_r        <= '0;
      known_r      <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) heap_base_r <= cfg_data;
        if (cfg_index == REG_HEAP_LIMIT) heap_limit_r <= cfg_data;
      end
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_data.cmd;
            size_r  <= in_data.req_size;
            addr_r  <= in_data.payload_addr;
            need_r  <= (in_data.req_size + 32'd7) & ~32'd7;
            st_r    <= ST_FAIL;
            res_r   <= '0;
            src_r   <= '0;
            byt_r   <= '0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (cmd_r == CMD_ALLOC || (cmd_r == CMD_RESIZE && addr_r == '0)) begin
            if (size_r == '0 || size_r > SIZE_MAX) begin
              state_r <= S_OUT;
            end else begin
              if (!known_r) begin
                brk_r   <= heap_base_r;
                known_r <= 1'b1;
              end
              ret_r        <= RET_ALLOC;
              flow_alloc_r <= 1'b1;
              state_r      <= S_MATCH;
            end
          end else if (cmd_r == CMD_RELEASE) begin
            st_r         <= ST_IGN;
            ret_r        <= RET_REL;
            flow_alloc_r <= 1'b0;
            state_r      <= (addr_r == '0) ? S_OUT : S_MATCH;
          end else if (cmd_r == CMD_RESIZE) begin
            flow_alloc_r <= 1'b0;
            if (size_r == '0) begin
              ret_r   <= RET_RZ0;
              state_r <= S_MATCH;
            end else if (size_r > SIZE_MAX) begin
              state_r <= S_OUT;
            end else begin
              ret_r   <= RET_RSZ;
              state_r <= S_MATCH;
            end
          end else begin
            st_r    <= ST_IGN;
            state_r <= S_OUT;
          end
        end
        S_MATCH: state_r <= S_PICK;
        S_PICK:  state_r <= S_READ;
        S_READ: begin
          found_r  <= p_found;
          idx_r    <= p_idx;
          cur_r    <= p_cur;
          nxt_r    <= p_nxt;
          prv_r    <= p_prv;
          nxt_ok_r <= ({1'b0, p_idx} + CW'(1)) < count_r;
          prv_ok_r <= p_idx != '0;
          state_r  <= flow_alloc_r ? S_ADEC : S_FDEC;
        end
        S_ADEC: begin
          if (found_r) begin
            new_addr_r <= cur_r.base + 32'(HEADER_BYTES);
            state_r    <= fits_split ? S_ASPLIT_W : S_AUSE;
          end else if (ext_over || count_r >= CW'(SEGMENTS)) begin
            st_r    <= ST_FAIL;
            state_r <= S_OUT;
          end else begin
            new_addr_r <= brk_r + 32'(HEADER_BYTES);
            state_r    <= S_AEXT;
          end
        end
        S_ASPLIT_W: state_r <= S_ASPLIT_I;
        S_ASPLIT_I, S_AUSE, S_AEXT: begin
          if (state_r == S_ASPLIT_I || state_r == S_AEXT) count_r <= count_r + CW'(1);
          if (state_r == S_AEXT) brk_r <= brk_r + 32'(HEADER_BYTES) + need_r;
          if (ret_r == RET_MOVE) begin
            ret_r        <= RET_MOVEREL;
            flow_alloc_r <= 1'b0;
            state_r      <= S_MATCH;
          end else begin
            st_r    <= ST_OK;
            res_r   <= (state_r == S_AEXT) ? brk_r + 32'(HEADER_BYTES) : new_addr_r;
            state_r <= S_OUT;
          end
        end
        S_FDEC: begin
          if (!found_r || cur_r.free) begin
            st_r    <= (ret_r == RET_RZ0) ? ST_FAIL : ST_IGN;
            state_r <= S_OUT;
          end else if (ret_r == RET_RSZ) begin
            if (cur_r.len >= need_r) begin
              st_r    <= ST_OK;
              res_r   <= addr_r;
              state_r <= S_OUT;
            end else if (merge_nxt &&
                         ({2'b0, cur_r.len} + 34'(HEADER_BYTES) + {2'b0, nxt_r.len}) >=
                         {2'b0, need_r}) begin
              state_r <= S_RABS;
            end else begin
              old_len_r <= cur_r.len;
              if (!known_r) begin
                brk_r   <= heap_base_r;
                known_r <= 1'b1;
              end
              ret_r        <= RET_MOVE;
              flow_alloc_r <= 1'b1;
              state_r      <= S_MATCH;
            end
          end else begin
            state_r <= S_R1;
          end
        end
        S_RABS: state_r <= S_RABS_R;
        S_RABS_R: begin
          count_r <= count_r - CW'(1);
          st_r    <= ST_OK;
          res_r   <= addr_r;
          state_r <= S_OUT;
        end
        S_R1: begin
          cur_r.free <= 1'b1;
          if (merge_nxt) begin
            cur_r.len <= sum_nxt;
            state_r   <= S_R1RM;
          end else begin
            state_r <= S_R2;
          end
        end
        S_R1RM: begin
          count_r <= count_r - CW'(1);
          state_r <= S_R2;
        end
        S_R2: begin
          if (merge_prv) begin
            cur_r.base <= prv_r.base;
            cur_r.len  <= sum_prv;
            idx_r      <= idx_r - IW'(1);
            state_r    <= S_R2RM;
          end else begin
            state_r <= S_R3;
          end
        end
        S_R2RM: begin
          count_r <= count_r - CW'(1);
          state_r <= S_R3;
        end
        S_R3: begin
          if (idx_p1 == count_r) begin
            brk_r   <= cur_r.base;
            state_r <= S_R3RM;
          end else begin
            state_r <= S_RDONE;
          end
        end
        S_R3RM: begin
          count_r <= count_r - CW'(1);
          state_r <= S_RDONE;
        end
        S_RDONE: begin
          case (ret_r)
            RET_RZ0: st_r <= ST_FAIL;
            RET_MOVEREL: begin
              st_r  <= ST_OK;
              res_r <= new_addr_r;
              src_r <= addr_r;
              byt_r <= old_len_r;
            end
            default: st_r <= ST_OK;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.status      <= st_r;
            out_r.result_addr <= res_r;
            out_r.copy_source <= src_r;
            out_r.copy_bytes  <= byt_r;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
